>>> design/dexp_pkg.sv
// Package for the difference expansion pair embedder: word types, stage types and codes.
package dexp_pkg;

  localparam logic       OP_EMBED       = 1'b0;
  localparam logic       OP_RESTORE     = 1'b1;

  localparam logic [1:0] CLS_ZERO       = 2'd0;
  localparam logic [1:0] CLS_EXPANDABLE = 2'd1;
  localparam logic [1:0] CLS_CHANGEABLE = 2'd2;
  localparam logic [1:0] CLS_FIXED      = 2'd3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd5;
  localparam logic [7:0] PIXEL_MAX       = 8'd255;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic       hide_bit;
    logic       hide_present;
    logic       map_flag;
    logic       restore_lsb;
    logic       last_pair;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_pixel_a;
    logic [7:0] out_pixel_b;
    logic [1:0] pair_class;
    logic       expand_mark;
    logic       spare_lsb;
    logic       spare_lsb_valid;
    logic       recovered_bit;
    logic       recovered_valid;
    logic       lsb_taken;
    logic       final_pair;
  } out_word_t;

  typedef struct packed {
    in_word_t          word;
    logic [7:0]        avg;
    logic signed [8:0] diff;
    logic [9:0]        bound;
  } stage1_t;

  typedef struct packed {
    logic [7:0]         pixel_a;
    logic [7:0]         pixel_b;
    logic [7:0]         avg;
    logic signed [10:0] new_diff;
    logic               modified;
    logic [1:0]         pair_class;
    logic               expand_mark;
    logic               spare_lsb;
    logic               spare_lsb_valid;
    logic               recovered_bit;
    logic               recovered_valid;
    logic               lsb_taken;
    logic               final_pair;
  } stage2_t;

endpackage

>>> design/difference_expansion_pair_embedder_core.sv
// Difference expansion pair embedder and restorer: three-stage pipeline core.
//
//   Channel  Ports                                  Direction  Payload
//   input    in_valid, in_ready, in_data            in         in_word_t
//   result   out_valid, out_ready, out_data         out        out_word_t
//   config   cfg_wr_en, cfg_wr_data                 in         expand threshold
//
// One word per cycle is taken unless a held output has filled the pipeline.
// Stages are average and difference, then classification and new difference,
// then pixel rebuild with saturation into the output register.
// Reset clears the stage valid bits and sets the threshold to 5.
// A stalled output holds its word, and earlier stages keep filling bubbles.
module difference_expansion_pair_embedder_core
  import dexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] threshold_r;
  logic       v1_r, v2_r, v3_r;
  stage1_t    s1_r, s1_nxt;
  stage2_t    s2_r, s2_nxt;
  out_word_t  s3_r, s3_nxt;
  logic       en1, en2, en3;

  function automatic logic fits(input logic signed [8:0] hv, input logic [9:0] bnd);
    logic signed [10:0] t1;
    logic signed [10:0] t0;
    logic [10:0]        a1;
    logic [10:0]        a0;
    t1 = {hv[8], hv, 1'b1};
    t0 = {hv[8], hv, 1'b0};
    a1 = t1[10] ? 11'(-t1) : 11'(t1);
    a0 = t0[10] ? 11'(-t0) : 11'(t0);
    return (a1 <= {1'b0, bnd}) && (a0 <= {1'b0, bnd});
  endfunction

  assign en3      = out_ready || !v3_r;
  assign en2      = en3 || !v2_r;
  assign en1      = en2 || !v1_r;
  assign in_ready = en1;
  assign out_valid = v3_r;
  assign out_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 1: integer average, difference and range bound.
  always_comb begin
    logic [8:0] sum;
    logic [9:0] hi;
    logic [9:0] lo;
    sum           = {1'b0, in_data.pixel_a} + {1'b0, in_data.pixel_b};
    s1_nxt.word   = in_data;
    s1_nxt.avg    = sum[8:1];
    s1_nxt.diff   = $signed({1'b0, in_data.pixel_a}) - $signed({1'b0, in_data.pixel_b});
    hi            = {1'b0, PIXEL_MAX - sum[8:1], 1'b0};
    lo            = {1'b0, sum[8:1], 1'b1};
    s1_nxt.bound  = (hi < lo) ? hi : lo;
  end

  // Stage 2: classification and the new difference.
  always_comb begin
    logic signed [8:0] h;
    logic signed [8:0] hf;
    logic [8:0]        habs;
    logic [1:0]        cls;
    logic              small_diff;
    h          = s1_r.diff;
    hf         = {h[8], h[8:1]};
    habs       = h[8] ? 9'(-h) : 9'(h);
    small_diff = (h == 9'sd0) || (h == -9'sd1);
    if (fits(h, s1_r.bound)) begin
      cls = small_diff ? CLS_ZERO : CLS_EXPANDABLE;
    end else if (fits(hf, s1_r.bound)) begin
      cls = CLS_CHANGEABLE;
    end else begin
      cls = CLS_FIXED;
    end

    s2_nxt.pixel_a         = s1_r.word.pixel_a;
    s2_nxt.pixel_b         = s1_r.word.pixel_b;
    s2_nxt.avg             = s1_r.avg;
    s2_nxt.new_diff        = {{2{h[8]}}, h};
    s2_nxt.modified        = 1'b0;
    s2_nxt.pair_class      = cls;
    s2_nxt.expand_mark     = 1'b0;
    s2_nxt.spare_lsb       = 1'b0;
    s2_nxt.spare_lsb_valid = 1'b0;
    s2_nxt.recovered_bit   = 1'b0;
    s2_nxt.recovered_valid = 1'b0;
    s2_nxt.lsb_taken       = 1'b0;
    s2_nxt.final_pair      = s1_r.word.last_pair;

    if (cls != CLS_FIXED) begin
      if (s1_r.word.op == OP_EMBED) begin
        if (s1_r.word.hide_present) begin
          s2_nxt.modified = 1'b1;
          if ((cls == CLS_ZERO) ||
              ((cls == CLS_EXPANDABLE) && (habs <= {1'b0, threshold_r}))) begin
            s2_nxt.new_diff    = {h[8], h, s1_r.word.hide_bit};
            s2_nxt.expand_mark = 1'b1;
          end else begin
            s2_nxt.new_diff        = {hf[8], hf, s1_r.word.hide_bit};
            s2_nxt.spare_lsb       = h[0];
            s2_nxt.spare_lsb_valid = (h != 9'sd1) && (h != -9'sd2);
          end
        end
      end else begin
        s2_nxt.recovered_bit   = h[0];
        s2_nxt.recovered_valid = 1'b1;
        if (s1_r.word.hide_present) begin
          s2_nxt.modified = 1'b1;
          if (s1_r.word.map_flag) begin
            s2_nxt.new_diff = {{2{hf[8]}}, hf};
          end else if ((h == 9'sd0) || (h == 9'sd1)) begin
            s2_nxt.new_diff = 11'sd1;
          end else if ((h == -9'sd1) || (h == -9'sd2)) begin
            s2_nxt.new_diff = -11'sd2;
          end else begin
            s2_nxt.new_diff  = {hf[8], hf, s1_r.word.restore_lsb};
            s2_nxt.lsb_taken = 1'b1;
          end
        end
      end
    end
  end

  // Stage 3: rebuild the pixels from the average and the new difference.
  always_comb begin
    logic signed [11:0] nh1;
    logic signed [11:0] ha;
    logic signed [10:0] hb;
    logic [12:0]        a_full;
    logic [12:0]        b_full;
    logic [7:0]         a_sat;
    logic [7:0]         b_sat;
    nh1    = {s2_r.new_diff[10], s2_r.new_diff} + 12'sd1;
    ha     = nh1 >>> 1;
    hb     = s2_r.new_diff >>> 1;
    a_full = {5'b0, s2_r.avg} + {ha[11], ha};
    b_full = {5'b0, s2_r.avg} - {{2{hb[10]}}, hb};
    if (a_full[12]) begin
      a_sat = 8'd0;
    end else if (a_full[11:8] != 4'd0) begin
      a_sat = PIXEL_MAX;
    end else begin
      a_sat = a_full[7:0];
    end
    if (b_full[12]) begin
      b_sat = 8'd0;
    end else if (b_full[11:8] != 4'd0) begin
      b_sat = PIXEL_MAX;
    end else begin
      b_sat = b_full[7:0];
    end
    s3_nxt.out_pixel_a     = s2_r.modified ? a_sat : s2_r.pixel_a;
    s3_nxt.out_pixel_b     = s2_r.modified ? b_sat : s2_r.pixel_b;
    s3_nxt.pair_class      = s2_r.pair_class;
    s3_nxt.expand_mark     = s2_r.expand_mark;
    s3_nxt.spare_lsb       = s2_r.spare_lsb;
    s3_nxt.spare_lsb_valid = s2_r.spare_lsb_valid;
    s3_nxt.recovered_bit   = s2_r.recovered_bit;
    s3_nxt.recovered_valid = s2_r.recovered_valid;
    s3_nxt.lsb_taken       = s2_r.lsb_taken;
    s3_nxt.final_pair      = s2_r.final_pair;
  end

`ifndef ASSERT_OFF
  // An expanded pair must have been of the zero or expandable class.
  a_mark_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.expand_mark) |->
      (out_data.pair_class == CLS_ZERO || out_data.pair_class == CLS_EXPANDABLE))
    else $error("expanded word with wrong class");

  // A pair that cannot change carries no flags and passes its pixels unchanged.
  a_fixed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s2_r.pair_class == CLS_FIXED) |->
      (!s2_r.modified && !s2_r.expand_mark && !s2_r.spare_lsb_valid &&
       !s2_r.recovered_valid && !s2_r.lsb_taken))
    else $error("unchangeable pair carries flags");

  // Consuming a saved LSB only happens on a restore word, which also carries a recovered bit.
  a_taken_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.lsb_taken) |-> out_data.recovered_valid)
    else $error("lsb taken without recovered bit");

  // Expansion and LSB replacement exclude each other.
  a_mark_spare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.expand_mark && out_data.spare_lsb_valid))
    else $error("word both expanded and replaced");

  // A held output word blocks the middle stage only when that stage is full.
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ready && v2_r) |=> (v2_r && $stable(s2_r)))
    else $error("middle stage lost under stall");
`endif

endmodule
